[rtl/websocket_frame_deframer_core_assert.svh]
// Assertion macros for the WebSocket deframer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by the parser, the output skid stage and the top level.
package wsd_pkg;

  // Length field codes of the second header byte
  localparam logic [6:0] LEN7_MASK = 7'h7F;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended field byte counts
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [3:0] MASKKEY_BYTES = 4'd4;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Output tdata width: 8 + 64 + 1 + 8 = 81 bits, padded to 88
  localparam int OUT_TDATA_W = 88;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASKKEY = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  header_byte;
    logic [63:0] payload_length;
    logic        masked;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

[rtl/wsd_parse.sv]
// Frame parser: header state machine, length and mask key capture, unmasking.
// Depends on wsd_pkg for the phase type, length codes and result struct.
module wsd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  left_r, left_nxt;
  logic        mask_r, mask_nxt;
  logic [7:0]  key_r [4];
  logic [7:0]  key_nxt [4];
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [6:0]  len7;
  logic        do_len_done;
  logic        do_emit;

  // Next-state and result for one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    mask_nxt    = mask_r;
    key_nxt     = key_r;
    rem_nxt     = rem_r;
    idx_nxt     = idx_r;
    do_len_done = 1'b0;
    do_emit     = 1'b0;
    res_valid   = 1'b0;
    res.kind    = wsd_pkg::KIND_HEADER;
    res.data_byte = 8'd0;
    res.last    = 1'b0;
    len7        = in_byte[6:0] & wsd_pkg::LEN7_MASK;

    if (accept) begin
      case (phase_r)
        wsd_pkg::PH_SECOND: begin
          mask_nxt = in_byte[7];
          if (len7 == wsd_pkg::LEN_EXT16) begin
            len_nxt   = 64'd0;
            left_nxt  = wsd_pkg::EXT16_BYTES;
            phase_nxt = wsd_pkg::PH_EXTLEN;
          end else if (len7 == wsd_pkg::LEN_EXT64) begin
            len_nxt   = 64'd0;
            left_nxt  = wsd_pkg::EXT64_BYTES;
            phase_nxt = wsd_pkg::PH_EXTLEN;
          end else begin
            len_nxt     = {57'd0, len7};
            do_len_done = 1'b1;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          // Shift in the next big-endian length byte
          len_nxt  = {len_r[55:0], in_byte};
          left_nxt = left_r - 4'd1;
          if (left_nxt == 4'd0) begin
            do_len_done = 1'b1;
          end
        end
        wsd_pkg::PH_MASKKEY: begin
          key_nxt[idx_r] = in_byte;
          idx_nxt  = idx_r + 2'd1;
          left_nxt = left_r - 4'd1;
          if (left_nxt == 4'd0) begin
            do_emit = 1'b1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          res_valid     = 1'b1;
          res.kind      = wsd_pkg::KIND_PAYLOAD;
          res.data_byte = mask_r ? (in_byte ^ key_r[idx_r]) : in_byte;
          idx_nxt       = idx_r + 2'd1;
          rem_nxt       = rem_r - 64'd1;
          if (rem_nxt == 64'd0) begin
            res.last  = 1'b1;
            phase_nxt = wsd_pkg::PH_FIRST;
          end
        end
        default: begin
          hdr_nxt   = in_byte;
          phase_nxt = wsd_pkg::PH_SECOND;
        end
      endcase

      // Length known: collect the mask key or close the header
      if (do_len_done) begin
        if (mask_nxt) begin
          left_nxt  = wsd_pkg::MASKKEY_BYTES;
          idx_nxt   = 2'd0;
          phase_nxt = wsd_pkg::PH_MASKKEY;
        end else begin
          do_emit = 1'b1;
        end
      end

      // Header complete: emit the header result and arm the payload count
      if (do_emit) begin
        res_valid = 1'b1;
        rem_nxt   = len_nxt;
        idx_nxt   = 2'd0;
        if (len_nxt == 64'd0) begin
          res.last  = 1'b1;
          phase_nxt = wsd_pkg::PH_FIRST;
        end else begin
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
    end

    res.header_byte    = hdr_nxt;
    res.payload_length = len_nxt;
    res.masked         = mask_nxt;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_FIRST;
      hdr_r   <= 8'd0;
      len_r   <= 64'd0;
      left_r  <= 4'd0;
      mask_r  <= 1'b0;
      key_r   <= '{default: 8'd0};
      rem_r   <= 64'd0;
      idx_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      mask_r  <= mask_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[rtl/wsd_skid.sv]
// Result register with a skid entry, so the input side keeps moving while
// a result waits. Depends on wsd_pkg for the result struct.
module wsd_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  wsd_pkg::result_t out_data_r, out_data_nxt;
  wsd_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop        = out_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Refill the output from the skid entry first, then from a new transfer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

[rtl/websocket_frame_deframer_core.sv]
// WebSocket frame deframer: one received byte per transfer in, header and payload results out.
// A result is registered in the output register, or in the skid entry if the output is occupied.
// One byte per cycle while in_tready is high; input stalls while the skid entry holds a result.
// The two-entry output stage lets input continue while a result waits.
// Reset (synchronous, active low) returns the parser to the first header byte and empties
// the output stage.
module websocket_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [wsd_pkg::OUT_TDATA_W-1:0] out_tdata,
                                  // [7:0] header_byte, [71:8] payload_length,
                                  // [72] masked, [80:73] data_byte, [87:81] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast   // last
);

  logic             accept;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign accept = in_tvalid & in_tready;

  wsd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  // Pack result fields onto the stream
  assign out_tdata = {7'd0, out_res.data_byte, out_res.masked,
                      out_res.payload_length, out_res.header_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

[rtl/wsd_checker.sv]
// Port-level checker for the WebSocket deframer, bound to the top level.
// Depends on the assertion macro header and wsd_pkg.
`include "websocket_frame_deframer_core_assert.svh"

module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [wsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  logic hdr_out;

  assign hdr_out = out_tvalid && (out_tuser == wsd_pkg::KIND_HEADER);

  // A stalled result stays offered
  `WSD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // Input is held off only while the output stage is occupied
  `WSD_ASSERT_NOW(a_backpressure, !in_tready, out_tvalid, "input stalled with empty output")

  // Header results carry a zero data byte
  `WSD_ASSERT_NOW(a_hdr_data, hdr_out, out_tdata[80:73] == 8'd0, "header result with data byte")

  // An empty frame closes on its header result
  `WSD_ASSERT_NOW(a_empty_last, hdr_out && (out_tdata[71:8] == 64'd0), out_tlast, "empty frame not last")

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
